@@ rtl/lfo_curve_generator_defines.svh @@
// ----------------------------------------------------------------------------
// lfo_curve_generator_defines
// assertion macros used by the checker file of the lfo curve generator
// ----------------------------------------------------------------------------
`ifndef LFO_CURVE_GENERATOR_DEFINES_SVH
`define LFO_CURVE_GENERATOR_DEFINES_SVH

// concurrent assertion on a given clock and active-low reset
`define LFO_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent assertion on the block clock and reset
`define LFO_ASSERT(lbl, prop, msg) `LFO_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/lfo_pkg.sv @@
// ----------------------------------------------------------------------------
// lfo_pkg
// shared constants, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lfo_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MS_W       = 10;
  localparam int LFO_W      = 25;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_HZ    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_KIND  = 3'd5;

  localparam logic [2:0] CURVE_SINE     = 3'd0;
  localparam logic [2:0] CURVE_TRIANGLE = 3'd1;
  localparam logic [2:0] CURVE_RANDOM   = 3'd2;
  localparam logic [2:0] CURVE_SAW      = 3'd3;
  localparam logic [2:0] CURVE_SQUARE   = 3'd4;

  localparam logic signed [16:0] Q15_ONE    = 17'sd32768;
  localparam logic [15:0]        HELD_RESET = 16'd32768;

  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_INC  = 32'd1013904223;
  localparam logic [31:0] RNG_SEED = 32'h12345678;

  // 256000 = 125 * 2^11
  localparam int SPEED_FRAC_SHIFT = 11;
  localparam int DIVISOR_W        = 7;
  localparam int DIV_STEP_BITS    = 8;
  localparam logic [DIVISOR_W-1:0] DIV_START = 7'd127;
  localparam logic [DIVISOR_W-1:0] DIV_INC   = 7'd125;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] QS_DIV [8]  = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};

  typedef struct packed {
    logic in_load;
    logic eval;
    logic div_start;
    logic div_sel_start;
    logic base_from_quot;
    logic phase_update;
    logic curve_prep;
    logic curve_eval;
    logic mul_depth;
    logic mul_range;
    logic out_load;
  } lfo_cmd_t;

  typedef struct packed {
    logic adv;
    logic speed_nz;
    logic started;
    logic div_busy;
    logic out_free;
  } lfo_sts_t;

endpackage

@@ rtl/lfo_cdiv.sv @@
// ----------------------------------------------------------------------------
// lfo_cdiv
// restoring divider by a small latched divisor, several quotient bits a cycle
// ----------------------------------------------------------------------------
module lfo_cdiv #(
  parameter int DIVIDEND_W = 47
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [DIVIDEND_W-1:0]          dividend_i,
  input  logic [lfo_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                           busy_o,
  output logic [DIVIDEND_W-1:0]          quotient_o
);

  localparam int StepBits = lfo_pkg::DIV_STEP_BITS;
  localparam int PadW     = ((DIVIDEND_W + StepBits - 1) / StepBits) * StepBits;
  localparam int Cycles   = PadW / StepBits;
  localparam int CntW     = $clog2(Cycles + 1);
  localparam int DW       = lfo_pkg::DIVISOR_W;

  logic [PadW-1:0] work_q, work_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   div_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;

  always_comb begin
    logic [DW:0] trial;
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int b = 0; b < StepBits; b++) begin
      trial  = {rem_d, work_d[PadW-1]};
      work_d = {work_d[PadW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial     = trial - {1'b0, div_q};
        work_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(Cycles);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PadW'(dividend_i);
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = work_q[DIVIDEND_W-1:0];

endmodule

@@ rtl/lfo_dp.sv @@
// ----------------------------------------------------------------------------
// lfo_dp
// datapath: config registers, delay counter, phase accumulator, curves, scaling
// ----------------------------------------------------------------------------
module lfo_dp #(
  parameter int SINE_ENTRIES = 256,
  parameter int PHASE_BITS   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lfo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [lfo_pkg::MS_W-1:0]        elapsed_ms_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic signed [lfo_pkg::LFO_W-1:0] lfo_value_o,
  output logic                            cycle_wrapped_o,
  input  lfo_pkg::lfo_cmd_t               cmd_i,
  output lfo_pkg::lfo_sts_t               sts_o
);

  localparam int MsW      = lfo_pkg::MS_W;
  localparam int IncProdW = 16 + MsW;
  localparam int DivW     = IncProdW + PHASE_BITS - lfo_pkg::SPEED_FRAC_SHIFT;
  localparam int IdxW     = $clog2(SINE_ENTRIES);
  localparam int SeW      = $clog2(SINE_ENTRIES + 1);

  // sine table, built at elaboration
  typedef logic signed [16:0] sine_tab_t [SINE_ENTRIES];

  function automatic logic [63:0] quarter_sine(logic [63:0] u);
    logic [63:0]        th;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    th   = (u * lfo_pkg::HALF_PI_Q30) >> 30;
    t2   = (th * th) >> 30;
    term = th;
    acc  = $signed(th);
    for (int k = 0; k < 8; k++) begin
      term = ((term * t2) >> 30) / lfo_pkg::QS_DIV[k];
      if (k[0] == 1'b0) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    return (acc < 0) ? 64'd0 : acc;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] f;
    logic [63:0] u;
    logic [63:0] v;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      x = (64'(i) << 32) / SINE_ENTRIES;
      f = x & (lfo_pkg::Q30_ONE - 64'd1);
      u = x[30] ? lfo_pkg::Q30_ONE - f : f;
      v = (quarter_sine(u) + 64'd16384) >> 15;
      tab[i] = x[31] ? -$signed(v[16:0]) : $signed(v[16:0]);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // config registers
  logic [15:0] delay_ms_q, speed_hz_q, depth_gain_q;
  logic [6:0]  start_phase_q;
  logic [7:0]  range_scale_q;
  logic [2:0]  curve_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ms_q    <= '0;
      speed_hz_q    <= '0;
      start_phase_q <= '0;
      depth_gain_q  <= '0;
      range_scale_q <= '0;
      curve_kind_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lfo_pkg::REG_DELAY_MS:    delay_ms_q    <= cfg_data_i;
        lfo_pkg::REG_SPEED_HZ:    speed_hz_q    <= cfg_data_i;
        lfo_pkg::REG_START_PHASE: start_phase_q <= cfg_data_i[6:0];
        lfo_pkg::REG_DEPTH_GAIN:  depth_gain_q  <= cfg_data_i;
        lfo_pkg::REG_RANGE_SCALE: range_scale_q <= cfg_data_i[7:0];
        lfo_pkg::REG_CURVE_KIND:  curve_kind_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // state
  logic [MsW-1:0]        ms_q, ms_eff_q;
  logic [15:0]           de_q;
  logic                  outen_q, started_q, wrap_q, rng_step_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [PHASE_BITS:0]   base_q;
  logic [IdxW-1:0]       idx_q;
  logic [31:0]           rng_q;
  logic [15:0]           held_q;
  logic signed [16:0]    curve_q;
  logic signed [32:0]    prod_q;
  logic signed [24:0]    res_q;
  logic signed [24:0]    lfo_value_q;
  logic                  out_valid_q, wrap_out_q;

  // delay window
  logic [16:0]    de_sum, excess;
  logic           de_lt, in_delay, outen_d;
  logic [MsW-1:0] ms_eff_d;
  logic [15:0]    de_d;

  always_comb begin
    de_sum   = {1'b0, de_q} + 17'(ms_q);
    excess   = de_sum - {1'b0, delay_ms_q};
    de_lt    = de_q < delay_ms_q;
    in_delay = de_lt && (de_sum <= {1'b0, delay_ms_q});
    if (in_delay) begin
      de_d     = de_sum[15:0];
      ms_eff_d = ms_q;
    end else if (de_lt) begin
      de_d     = delay_ms_q;
      ms_eff_d = excess[MsW-1:0];
    end else begin
      de_d     = de_q;
      ms_eff_d = ms_q;
    end
    outen_d = (depth_gain_q != 16'd0) && (!in_delay || de_sum == {1'b0, delay_ms_q});
  end

  // phase increment and start phase through the shared divider
  logic [IncProdW-1:0]             inc_prod;
  logic [DivW-1:0]                 div_dividend, quot;
  logic [lfo_pkg::DIVISOR_W-1:0]   div_divisor;
  logic                            div_busy;
  logic [DivW:0]                   ph_sum;

  assign inc_prod     = IncProdW'(speed_hz_q) * IncProdW'(ms_eff_q);
  assign div_dividend = cmd_i.div_sel_start ? (DivW'(start_phase_q) << PHASE_BITS)
                      : (DivW'(inc_prod) << (PHASE_BITS - lfo_pkg::SPEED_FRAC_SHIFT));
  assign div_divisor  = cmd_i.div_sel_start ? lfo_pkg::DIV_START : lfo_pkg::DIV_INC;
  assign ph_sum       = (DivW + 1)'(base_q) + (DivW + 1)'(quot);

  lfo_cdiv #(
    .DIVIDEND_W(DivW)
  ) u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // curve evaluation
  logic [PHASE_BITS+SeW-1:0] idx_prod;
  logic [PHASE_BITS+16:0]    tri_ext;
  logic [PHASE_BITS+14:0]    saw_ext;
  logic [16:0]               tri_t, tri_val;
  logic [1:0]                seg;
  logic [16:0]               held_sum;
  logic [15:0]               held_new, held_use;
  logic [31:0]               rng_next;
  logic signed [16:0]        curve_d;
  logic signed [33:0]        prod_full;
  logic signed [17:0]        scaled;
  logic signed [26:0]        res_full;

  assign idx_prod = (PHASE_BITS + SeW)'(phase_q) * (PHASE_BITS + SeW)'(SINE_ENTRIES);
  assign tri_ext  = {phase_q, 17'd0};
  assign saw_ext  = {phase_q, 15'd0};
  assign tri_t    = tri_ext[PHASE_BITS +: 17];
  assign seg      = phase_q[PHASE_BITS-1 -: 2];
  assign tri_val  = (seg == 2'd1 || seg == 2'd2) ? 17'h10000 - tri_t : tri_t;
  assign held_sum = {1'b0, rng_q[31:16]} + 17'd1;
  assign held_new = held_sum[16:1];
  assign held_use = rng_step_q ? held_new : held_q;
  assign rng_next = rng_q * lfo_pkg::LCG_MUL + lfo_pkg::LCG_INC;

  always_comb begin
    case (curve_kind_q)
      lfo_pkg::CURVE_SINE:     curve_d = SINE_TAB[idx_q];
      lfo_pkg::CURVE_TRIANGLE: curve_d = $signed(tri_val);
      lfo_pkg::CURVE_RANDOM:   curve_d = $signed({1'b0, held_use});
      lfo_pkg::CURVE_SAW:      curve_d = $signed({2'b00, saw_ext[PHASE_BITS +: 15]});
      lfo_pkg::CURVE_SQUARE:   curve_d = phase_q[PHASE_BITS-1] ? lfo_pkg::Q15_ONE : 17'sd0;
      default:                 curve_d = lfo_pkg::Q15_ONE;
    endcase
  end

  assign prod_full = curve_q * $signed({1'b0, depth_gain_q});
  assign scaled    = prod_q[32:15];
  assign res_full  = scaled * $signed({1'b0, range_scale_q});

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      de_q        <= '0;
      outen_q     <= 1'b0;
      started_q   <= 1'b0;
      wrap_q      <= 1'b0;
      phase_q     <= '0;
      rng_q       <= lfo_pkg::RNG_SEED;
      rng_step_q  <= 1'b0;
      held_q      <= lfo_pkg::HELD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        de_q    <= de_d;
        outen_q <= outen_d;
      end
      if (cmd_i.phase_update) begin
        phase_q   <= ph_sum[PHASE_BITS-1:0];
        wrap_q    <= |ph_sum[DivW:PHASE_BITS];
        started_q <= 1'b1;
      end
      if (cmd_i.curve_prep) begin
        rng_step_q <= (curve_kind_q == lfo_pkg::CURVE_RANDOM) && wrap_q && outen_q;
        if ((curve_kind_q == lfo_pkg::CURVE_RANDOM) && wrap_q && outen_q) begin
          rng_q <= rng_next;
        end
      end
      if (cmd_i.curve_eval && rng_step_q) begin
        held_q <= held_new;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      ms_q <= elapsed_ms_i;
    end
    if (cmd_i.eval) begin
      ms_eff_q <= ms_eff_d;
      base_q   <= {1'b0, phase_q};
    end
    if (cmd_i.base_from_quot) begin
      base_q <= quot[PHASE_BITS:0];
    end
    if (cmd_i.curve_prep) begin
      idx_q <= idx_prod[PHASE_BITS +: IdxW];
    end
    if (cmd_i.curve_eval) begin
      curve_q <= curve_d;
    end
    if (cmd_i.mul_depth) begin
      prod_q <= prod_full[32:0];
    end
    if (cmd_i.mul_range) begin
      res_q <= outen_q ? res_full[24:0] : 25'sd0;
    end
    if (cmd_i.out_load) begin
      lfo_value_q <= res_q;
      wrap_out_q  <= wrap_q;
    end
  end

  assign sts_o.adv      = !in_delay;
  assign sts_o.speed_nz = |speed_hz_q;
  assign sts_o.started  = started_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign lfo_value_o     = lfo_value_q;
  assign cycle_wrapped_o = wrap_out_q;

endmodule

@@ rtl/lfo_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfo_ctrl
// controller: sequences one tick word through delay, phase, curve and scaling
// ----------------------------------------------------------------------------
module lfo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lfo_pkg::lfo_sts_t sts_i,
  output lfo_pkg::lfo_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_EVAL       = 4'd1;
  localparam logic [3:0] S_START_WAIT = 4'd2;
  localparam logic [3:0] S_INC_GO     = 4'd3;
  localparam logic [3:0] S_INC_WAIT   = 4'd4;
  localparam logic [3:0] S_CURVE      = 4'd5;
  localparam logic [3:0] S_CURVE2     = 4'd6;
  localparam logic [3:0] S_MUL1       = 4'd7;
  localparam logic [3:0] S_MUL2       = 4'd8;
  localparam logic [3:0] S_DONE       = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.adv && sts_i.speed_nz) begin
          if (sts_i.started) begin
            state_d = S_INC_GO;
          end else begin
            cmd_o.div_start     = 1'b1;
            cmd_o.div_sel_start = 1'b1;
            state_d             = S_START_WAIT;
          end
        end else begin
          state_d = S_CURVE;
        end
      end
      S_START_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.base_from_quot = 1'b1;
          state_d              = S_INC_GO;
        end
      end
      S_INC_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_INC_WAIT;
      end
      S_INC_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.phase_update = 1'b1;
          state_d            = S_CURVE;
        end
      end
      S_CURVE: begin
        cmd_o.curve_prep = 1'b1;
        state_d          = S_CURVE2;
      end
      S_CURVE2: begin
        cmd_o.curve_eval = 1'b1;
        state_d          = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_depth = 1'b1;
        state_d         = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_range = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ rtl/lfo_curve_generator.sv @@
// sequence: a word runs evaluation, curve preparation and evaluation, the depth and
//   range multiplies and the output load, which waits while the output is stalled;
//   an advancing phase first runs the shared constant divider for the start phase
//   (first advance only) and then for the increment; one word is in flight at a time
// reset: control and config state clears at once, payload does not, no clearing pass
// ----------------------------------------------------------------------------
// lfo_curve_generator
// low-frequency oscillator on a millisecond tick stream, controller and datapath
// ----------------------------------------------------------------------------
module lfo_curve_generator #(
  parameter int SINE_ENTRIES = 256,
  parameter int PHASE_BITS   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lfo_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lfo_pkg::MS_W-1:0]         elapsed_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [lfo_pkg::LFO_W-1:0] lfo_value_o,
  output logic                             cycle_wrapped_o
);

  lfo_pkg::lfo_cmd_t cmd;
  lfo_pkg::lfo_sts_t sts;

  lfo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfo_dp #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .PHASE_BITS   (PHASE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .lfo_value_o     (lfo_value_o),
    .cycle_wrapped_o (cycle_wrapped_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ rtl/lfo_checker.sv @@
// ----------------------------------------------------------------------------
// lfo_checker
// port-level checks of the lfo curve generator, bound to the top level
// ----------------------------------------------------------------------------
`include "lfo_curve_generator_defines.svh"

module lfo_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [lfo_pkg::LFO_W-1:0] lfo_value_o,
  input logic                             cycle_wrapped_o
);

  // one word in flight: no new word right after one is taken
  `LFO_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "accepted twice")

  // a fresh result leaves the block ready for the next word
  `LFO_ASSERT(a_ready_on_result, $rose(out_valid_o) |-> in_ready_o, "result without idle")

  // a stalled result holds
  `LFO_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(lfo_value_o) && $stable(cycle_wrapped_o), "stalled word changed")

endmodule

bind lfo_curve_generator lfo_checker u_lfo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .lfo_value_o     (lfo_value_o),
  .cycle_wrapped_o (cycle_wrapped_o)
);
